@@ src/acnt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acnt_pkg: shared types and constants of the attribute counter table
// Table size, address width, command codes and the item structs.
// ----------------------------------------------------------------------------
package acnt_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int COUNT_W       = 32;
    localparam int ENTRY_W       = COUNT_W + 1;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] attr_id;
        logic [31:0] amount;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic        recorded;
        logic [31:0] count_value;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } t_entry;

endpackage

@@ src/attribute_counter_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attribute_counter_table: table of 32-bit statistic counters
// Add, clear and read commands on counters addressed by attribute id 1..N.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid, o_in_stall  i_in_item  (cmd, attr_id, amount)
// out       output     o_out_valid, i_out_stall o_out_item (status, recorded, count)
//
// An add or read reads the table RAM when the item is taken, then its execute
// step modifies, writes back and loads the output register; the registered
// RAM read data sets this. Reset and every clear command sweep the RAM, one
// entry a cycle, over all TABLE_ENTRIES (1024) entries while o_in_stall stays high.
// A result waits in the output register; a new item is taken meanwhile, and
// its execute step holds until the output register frees.
// ----------------------------------------------------------------------------
module attribute_counter_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  acnt_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output acnt_pkg::t_out_item o_out_item
);

    import acnt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_CLEAR = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out_item, n_out_item;
    logic [1:0]      r_cmd;
    logic            r_id_ok;
    logic [31:0]     r_amount;
    logic [ADDR_W-1:0] r_addr;

    logic            in_accept;
    logic            id_ok;
    logic            out_free;
    logic            wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry          wr_data;
    t_entry          rd_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic [COUNT_W-1:0] sum;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign id_ok     = (i_in_item.attr_id != 32'd0)
                    && (i_in_item.attr_id <= 32'(TABLE_ENTRIES));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign rd_entry  = t_entry'(rd_data);
    assign sum       = rd_entry.valid ? rd_entry.count + r_amount : r_amount;

    acnt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (ADDR_W'(i_in_item.attr_id - 32'd1)),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        wr_en       = 1'b0;
        wr_addr     = r_addr;
        wr_data     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '0;
                    n_state     = ST_IDLE;
                    priority if (r_cmd == CMD_ADD) begin
                        if (r_id_ok) begin
                            wr_en                  = 1'b1;
                            wr_data.valid          = 1'b1;
                            wr_data.count          = sum;
                            n_out_item.recorded    = 1'b1;
                            n_out_item.count_value = sum;
                        end else begin
                            n_out_item.status = 1'b1;
                        end
                    end else if (r_cmd == CMD_READ) begin
                        if (r_id_ok) begin
                            n_out_item.recorded    = rd_entry.valid;
                            n_out_item.count_value = rd_entry.valid ? rd_entry.count : '0;
                        end else begin
                            n_out_item.status = 1'b1;
                        end
                    end else if (r_cmd == CMD_CLEAR) begin
                        n_state    = ST_CLEAR;
                        n_clr_addr = '0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(TABLE_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        if (in_accept) begin
            r_cmd    <= i_in_item.cmd;
            r_id_ok  <= id_ok;
            r_amount <= i_in_item.amount;
            r_addr   <= ADDR_W'(i_in_item.attr_id - 32'd1);
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ src/acnt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acnt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module acnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/acnt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acnt_checker: port-level checks of the attribute counter table
// Watches the top-level ports and flags reset, interlock and result slips.
// ----------------------------------------------------------------------------
module acnt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input acnt_pkg::t_out_item o_out_item
);

    import acnt_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    a_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("item taken while previous item executes");

    a_bad_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status) |->
            (!o_out_item.recorded && o_out_item.count_value == 32'd0))
        else $error("error result carries data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind attribute_counter_table acnt_checker u_acnt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ sim/attribute_counter_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attribute_counter_table_test: self-checking bench for the counter table
// A directed table of add, read, clear and unused commands runs first, then
// random traffic that is biased to a few hot ids so that counters accumulate
// and wrap. Each result is checked against its fixed row value or a behavioral copy.
// Sender gaps and receiver stalls vary by phase, and one long output stall
// lets the block back up into its input.
// ----------------------------------------------------------------------------
module attribute_counter_table_test;
    import acnt_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1000;
    localparam int         PHASES       = 4;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         CYCLE_LIMIT  = 400000;

    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item result;
    } t_drill_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    bit          table_recorded [TABLE_ENTRIES];
    logic [31:0] table_count    [TABLE_ENTRIES];
    t_out_item   pending_results[$];
    t_drill_row  drill_rows[$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_requests  = 0;
    int unsigned error_count    = 0;

    attribute_counter_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic t_out_item apply_command(input t_in_item it);
        t_out_item   res;
        logic [31:0] slot;
        res  = '0;
        slot = it.attr_id - 32'd1;
        case (it.cmd)
            CMD_ADD, CMD_READ: begin
                if (it.attr_id == 32'd0 || it.attr_id > 32'(TABLE_ENTRIES)) begin
                    res.status = 1'b1;
                end else if (it.cmd == CMD_ADD) begin
                    if (table_recorded[slot[ADDR_W-1:0]])
                        table_count[slot[ADDR_W-1:0]] =
                            table_count[slot[ADDR_W-1:0]] + it.amount;
                    else
                        table_count[slot[ADDR_W-1:0]] = it.amount;
                    table_recorded[slot[ADDR_W-1:0]] = 1'b1;
                    res.recorded    = 1'b1;
                    res.count_value = table_count[slot[ADDR_W-1:0]];
                end else if (table_recorded[slot[ADDR_W-1:0]]) begin
                    res.recorded    = 1'b1;
                    res.count_value = table_count[slot[ADDR_W-1:0]];
                end
            end
            CMD_CLEAR: begin
                for (int k = 0; k < TABLE_ENTRIES; k++) begin
                    table_recorded[k] = 1'b0;
                    table_count[k]    = '0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_in_item random_command();
        t_in_item    it;
        int unsigned pick;
        pick = $urandom_range(999);
        if (pick < 4)
            it.cmd = CMD_CLEAR;
        else if (pick < 12)
            it.cmd = CMD_UNUSED;
        else if (pick < 600)
            it.cmd = CMD_ADD;
        else
            it.cmd = CMD_READ;
        pick = $urandom_range(99);
        if (pick < 70)
            it.attr_id = $urandom_range(24, 1);
        else if (pick < 80)
            it.attr_id = $urandom_range(TABLE_ENTRIES, 1);
        else if (pick < 84)
            it.attr_id = 32'(TABLE_ENTRIES);
        else if (pick < 88)
            it.attr_id = 32'd0;
        else if (pick < 92)
            it.attr_id = 32'(TABLE_ENTRIES + 1);
        else
            it.attr_id = $urandom;
        case ($urandom_range(3))
            0:       it.amount = $urandom_range(15);
            1:       it.amount = 32'hFFFF_FFFF - $urandom_range(3);
            default: it.amount = $urandom;
        endcase
        return it;
    endfunction

    task automatic add_row(input logic [1:0] cmd, input logic [31:0] id,
                           input logic [31:0] amount, input bit fixed,
                           input logic status, input logic recorded,
                           input logic [31:0] count);
        t_drill_row row;
        row.item.cmd            = cmd;
        row.item.attr_id        = id;
        row.item.amount         = amount;
        row.fixed               = fixed;
        row.result.status       = status;
        row.result.recorded     = recorded;
        row.result.count_value  = count;
        drill_rows.push_back(row);
    endtask

    // offer one item, hold it until taken, then queue its result
    task automatic put_item(input t_in_item item, input bit fixed,
                            input t_out_item fixed_result);
        t_out_item predicted;
        bit        taken;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        predicted = apply_command(item);
        pending_results.push_back(fixed ? fixed_result : predicted);
    endtask

    initial begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin
        t_out_item want;
        forever begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result with no item pending, actual %0b %0b %h",
                             $time, out_item.status, out_item.recorded,
                             out_item.count_value);
                end else begin
                    want = pending_results.pop_front();
                    if (out_item.status !== want.status) begin
                        error_count++;
                        $display("%0t: status mismatch, expected %0b, actual %0b",
                                 $time, want.status, out_item.status);
                    end
                    if (out_item.recorded !== want.recorded) begin
                        error_count++;
                        $display("%0t: recorded mismatch, expected %0b, actual %0b",
                                 $time, want.recorded, out_item.recorded);
                    end
                    if (out_item.count_value !== want.count_value) begin
                        error_count++;
                        $display("%0t: count mismatch, expected %h, actual %h",
                                 $time, want.count_value, out_item.count_value);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("** attribute_counter_table: FAILED **");
        $finish;
    end

    initial begin
        t_out_item none;
        none = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            table_recorded[k] = 1'b0;
            table_count[k]    = '0;
        end

        add_row(CMD_READ,   32'd1,            32'd0,            1, 0, 0, 32'd0);
        add_row(CMD_READ,   32'd1024,         32'hFFFF_FFFF,    1, 0, 0, 32'd0);
        add_row(CMD_ADD,    32'd0,            32'd5,            1, 1, 0, 32'd0);
        add_row(CMD_ADD,    32'd1025,         32'd5,            1, 1, 0, 32'd0);
        add_row(CMD_ADD,    32'hFFFF_FFFF,    32'hFFFF_FFFF,    1, 1, 0, 32'd0);
        add_row(CMD_READ,   32'd0,            32'd0,            1, 1, 0, 32'd0);
        add_row(CMD_READ,   32'd1025,         32'd0,            1, 1, 0, 32'd0);
        add_row(CMD_READ,   32'h8000_0000,    32'd0,            1, 1, 0, 32'd0);
        add_row(CMD_ADD,    32'd1,            32'hFFFF_FFFF,    1, 0, 1, 32'hFFFF_FFFF);
        add_row(CMD_ADD,    32'd1,            32'd1,            1, 0, 1, 32'd0);
        add_row(CMD_ADD,    32'd1024,         32'd0,            1, 0, 1, 32'd0);
        add_row(CMD_READ,   32'd1024,         32'd0,            1, 0, 1, 32'd0);
        add_row(CMD_ADD,    32'd1,            32'h1234_5678,    0, 0, 0, 32'd0);
        add_row(CMD_READ,   32'd1,            32'd0,            0, 0, 0, 32'd0);
        add_row(CMD_UNUSED, 32'd1,            32'hFFFF_FFFF,    1, 0, 0, 32'd0);
        add_row(CMD_UNUSED, 32'd0,            32'd0,            1, 0, 0, 32'd0);
        add_row(CMD_READ,   32'd1,            32'd0,            0, 0, 0, 32'd0);
        add_row(CMD_ADD,    32'd2,            32'hAAAA_5555,    1, 0, 1, 32'hAAAA_5555);
        add_row(CMD_ADD,    32'd2,            32'h5555_AAAA,    0, 0, 0, 32'd0);
        add_row(CMD_CLEAR,  32'hFFFF_FFFF,    32'hFFFF_FFFF,    1, 0, 0, 32'd0);
        add_row(CMD_READ,   32'd2,            32'd0,            1, 0, 0, 32'd0);
        add_row(CMD_READ,   32'd1024,         32'd0,            1, 0, 0, 32'd0);
        add_row(CMD_ADD,    32'd2,            32'd7,            1, 0, 1, 32'd7);
        add_row(CMD_ADD,    32'd1023,         32'h8000_0001,    0, 0, 0, 32'd0);
        add_row(CMD_READ,   32'd1023,         32'd0,            0, 0, 0, 32'd0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (drill_rows[r])
            put_item(drill_rows[r].item, drill_rows[r].fixed, drill_rows[r].result);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_requests++;
                end
                1: begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                end
                default: begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                put_item(random_command(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** attribute_counter_table: PASSED **");
        else
            $display("** attribute_counter_table: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
src/acnt_pkg.sv
src/acnt_ram.sv
src/attribute_counter_table.sv
src/acnt_checker.sv
sim/attribute_counter_table_test.sv
